// File: hdl/fpsc_pkg.sv
// ----------------------------------------------------------------------------
// fpsc_pkg
// Shared constants, register codes and pipeline flag types for the
// five-point stencil clamp unit.
// ----------------------------------------------------------------------------
package fpsc_pkg;

    // Default sizes for the top-level parameters.
    localparam int MAX_GRID_DEF  = 1024;
    localparam int FRAC_BITS_DEF = 16;

    // Integer bits of a cell value and the largest integer value kept.
    localparam int INT_BITS      = 7;
    localparam int VALUE_INT_MAX = 127;

    // Configuration port.
    localparam int GRID_W        = 11;
    localparam int GAIN_W        = 16;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int GRID_RESET    = 1024;
    localparam int GAIN_RESET    = 15729;
    localparam int SIDE_MIN      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_SIZE = 2'd0,
        REG_GAIN      = 2'd1
    } cfg_reg_t;

    // What one input cell causes, carried down the pipeline.
    typedef struct packed {
        logic has_first;   // a stencil result for the row above
        logic interior;    // that result uses the full stencil
        logic has_second;  // last row: the cell itself passes through
        logic eof;         // the pass-through result is the final grid cell
    } fpsc_flags_t;

endpackage

// File: hdl/five_point_stencil_clamp_unit.sv
// ----------------------------------------------------------------------------
// five_point_stencil_clamp_unit
// One sweep of a five-point Laplacian stencil over a square raster grid.
// ----------------------------------------------------------------------------
// Cells stream in raster order, one request per cycle while s_tready is high;
// each interior cell of the row above becomes clamp(c + gain * (up + down +
// left + right - 4c), 0, 127) in unsigned Q7.FRAC_BITS, with the product
// floored by 16 bits, and border cells pass through. A line store of MAX_GRID
// words holds the two previous rows; every request does one read (column x+1)
// and one write-back (column x), so the block takes one cell per cycle unless
// the output slots are full; a request's results pass the read-return,
// Laplacian, product and output registers in turn. Cells of the first row give
// no result; cells of the last row give two, and since at most one result leaves
// per cycle the input stalls while the second waits in the extra slot. Writing
// grid_size restarts the frame; the line store needs no clearing after reset.
// ----------------------------------------------------------------------------
module five_point_stencil_clamp_unit #(
    parameter int MAX_GRID  = fpsc_pkg::MAX_GRID_DEF,
    parameter int FRAC_BITS = fpsc_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Input cells.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((fpsc_pkg::INT_BITS+FRAC_BITS+7)/8)*8-1:0] s_tdata,  // [DATA_W-1:0] in_value
    // Results.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((fpsc_pkg::INT_BITS+FRAC_BITS+7)/8)*8-1:0] m_tdata,  // [DATA_W-1:0] out_value
    output logic                                   m_tlast,  // last_in_run
    output logic                                   m_tuser,  // end_of_frame
    // Configuration writes.
    input  logic                                   cfg_we,
    input  logic [fpsc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [fpsc_pkg::CFG_W-1:0]             cfg_data
);
    import fpsc_pkg::*;

    localparam int DATA_W  = INT_BITS + FRAC_BITS;
    localparam int TDATA_W = ((DATA_W + 7) / 8) * 8;
    localparam int ADDR_W  = $clog2(MAX_GRID);
    localparam int SIDE_W  = ADDR_W + 1;
    localparam int LAP_W   = DATA_W + 3;
    localparam logic [SIDE_W-1:0] SIDE_RESET =
        SIDE_W'((GRID_RESET > MAX_GRID) ? MAX_GRID : GRID_RESET);

    logic [SIDE_W-1:0]  side_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [ADDR_W-1:0]  col_reg;
    logic [ADDR_W-1:0]  row_reg;

    logic [SIDE_W-1:0]  side_next;
    logic [SIDE_W-1:0]  side_last;
    logic               col_last;
    logic               row_last;
    logic               accept;
    logic               adv;
    logic [ADDR_W-1:0]  rd_addr;
    fpsc_flags_t        in_flags;

    logic [DATA_W-1:0]  rd_older;
    logic [DATA_W-1:0]  rd_newer;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [DATA_W-1:0]  wr_older;
    logic [DATA_W-1:0]  wr_newer;

    logic               c_valid;
    logic signed [LAP_W-1:0] c_lap;
    logic [DATA_W-1:0]  c_center;
    logic [DATA_W-1:0]  c_value;
    fpsc_flags_t        c_flags;

    logic               d_valid;
    logic [DATA_W-1:0]  d_first;
    logic [DATA_W-1:0]  d_second;
    fpsc_flags_t        d_flags;
    logic               can_load;

    // Grid side saturated to 3 .. MAX_GRID.
    always_comb
    begin
        if (32'(cfg_data[GRID_W-1:0]) > 32'(MAX_GRID))
        begin
            side_next = SIDE_W'(MAX_GRID);
        end
        else if (32'(cfg_data[GRID_W-1:0]) < 32'(SIDE_MIN))
        begin
            side_next = SIDE_W'(SIDE_MIN);
        end
        else
        begin
            side_next = SIDE_W'(cfg_data[GRID_W-1:0]);
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_RESET;
            gain_reg <= GAIN_W'(GAIN_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_SIZE: side_reg <= side_next;
                REG_GAIN:      gain_reg <= cfg_data[GAIN_W-1:0];
                default:       ;
            endcase
        end
    end

    // The whole pipeline moves together unless the output slots are full.
    assign adv      = !d_valid || can_load;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    assign side_last = side_reg - SIDE_W'(1);
    assign col_last  = ({1'b0, col_reg} == side_last);
    assign row_last  = ({1'b0, row_reg} == side_last);

    // The border column wraps its lookahead read to column zero.
    assign rd_addr = col_last ? '0 : col_reg + ADDR_W'(1);

    always_comb
    begin
        in_flags.has_first  = (row_reg != '0);
        in_flags.interior   = (row_reg > ADDR_W'(1)) && (col_reg != '0) && !col_last;
        in_flags.has_second = row_last;
        in_flags.eof        = row_last && col_last;
    end

    // Raster position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_we && cfg_index == REG_GRID_SIZE)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (col_last)
            begin
                col_reg <= '0;
                row_reg <= row_last ? '0 : row_reg + ADDR_W'(1);
            end
            else
            begin
                col_reg <= col_reg + ADDR_W'(1);
            end
        end
    end

    fpsc_line_mem #(
        .DEPTH  (MAX_GRID),
        .DATA_W (DATA_W)
    ) u_line_mem (
        .clk      (clk),
        .rd_en    (accept),
        .rd_addr  (rd_addr),
        .rd_older (rd_older),
        .rd_newer (rd_newer),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_older (wr_older),
        .wr_newer (wr_newer)
    );

    fpsc_window #(
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .accept   (accept),
        .in_addr  (col_reg),
        .in_value (s_tdata[DATA_W-1:0]),
        .in_flags (in_flags),
        .rd_older (rd_older),
        .rd_newer (rd_newer),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_older (wr_older),
        .wr_newer (wr_newer),
        .c_valid  (c_valid),
        .c_lap    (c_lap),
        .c_center (c_center),
        .c_value  (c_value),
        .c_flags  (c_flags)
    );

    fpsc_update #(
        .FRAC_BITS (FRAC_BITS)
    ) u_update (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .gain     (gain_reg),
        .c_valid  (c_valid),
        .c_lap    (c_lap),
        .c_center (c_center),
        .c_value  (c_value),
        .c_flags  (c_flags),
        .d_valid  (d_valid),
        .d_first  (d_first),
        .d_second (d_second),
        .d_flags  (d_flags)
    );

    fpsc_out_buf #(
        .DATA_W  (DATA_W),
        .TDATA_W (TDATA_W)
    ) u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (adv && d_valid),
        .first    (d_first),
        .second   (d_second),
        .flags    (d_flags),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // The raster position always lies inside the grid.
    a_pos_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, col_reg} < side_reg) && ({1'b0, row_reg} < side_reg))
        else $error("raster position outside the grid");

    // The end-of-frame result is always the final result of its request.
    a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("end of frame without last_in_run");

    // Taking the final cell of the grid starts a new frame.
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && col_last && row_last |=> (col_reg == '0) && (row_reg == '0))
        else $error("frame did not wrap after the last cell");

    // The write-back never hits the column that the lookahead read is taking.
    a_wb_not_lookahead: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && accept |-> wr_addr != rd_addr)
        else $error("write-back and lookahead read hit the same column");

endmodule

// File: hdl/fpsc_line_mem.sv
// ----------------------------------------------------------------------------
// fpsc_line_mem
// Line store holding, per column, the two previous rows as one word
// {older, newer}. One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fpsc_line_mem #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 23
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_older,
    output logic [DATA_W-1:0]        rd_newer,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_older,
    input  logic [DATA_W-1:0]        wr_newer
);

    logic [2*DATA_W-1:0] mem [DEPTH];
    logic [2*DATA_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_older, wr_newer};
        end
    end

    // Read port, data held until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_older = rd_data_reg[2*DATA_W-1:DATA_W];
    assign rd_newer = rd_data_reg[DATA_W-1:0];

endmodule

// File: hdl/fpsc_window.sv
// ----------------------------------------------------------------------------
// fpsc_window
// Read-return stage: keeps the sliding window of the row being finished,
// writes the shifted rows back to the line store and forms the Laplacian.
// ----------------------------------------------------------------------------
module fpsc_window #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 23
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    accept,
    input  logic [ADDR_W-1:0]       in_addr,
    input  logic [DATA_W-1:0]       in_value,
    input  fpsc_pkg::fpsc_flags_t   in_flags,
    input  logic [DATA_W-1:0]       rd_older,
    input  logic [DATA_W-1:0]       rd_newer,
    output logic                    wr_en,
    output logic [ADDR_W-1:0]       wr_addr,
    output logic [DATA_W-1:0]       wr_older,
    output logic [DATA_W-1:0]       wr_newer,
    output logic                    c_valid,
    output logic signed [DATA_W+2:0] c_lap,
    output logic [DATA_W-1:0]       c_center,
    output logic [DATA_W-1:0]       c_value,
    output fpsc_pkg::fpsc_flags_t   c_flags
);
    import fpsc_pkg::*;

    localparam int SUM_W = DATA_W + 2;
    localparam int LAP_W = DATA_W + 3;

    logic               b_valid_reg;
    logic [ADDR_W-1:0]  b_addr_reg;
    logic [DATA_W-1:0]  b_value_reg;
    fpsc_flags_t        b_flags_reg;

    logic [DATA_W-1:0]  win_left_reg;
    logic [DATA_W-1:0]  win_center_reg;
    logic [DATA_W-1:0]  win_up_reg;

    logic               c_valid_reg;
    logic signed [LAP_W-1:0] c_lap_reg;
    logic [DATA_W-1:0]  c_center_reg;
    logic [DATA_W-1:0]  c_value_reg;
    fpsc_flags_t        c_flags_reg;

    logic [SUM_W-1:0]   sum4;
    logic [SUM_W-1:0]   four_c;
    logic signed [LAP_W-1:0] lap_next;
    logic               b_fire;

    assign b_fire = adv && b_valid_reg;

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= accept;
            c_valid_reg <= b_valid_reg;
        end
    end

    // Request registers of the read-return stage.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_addr_reg  <= in_addr;
            b_value_reg <= in_value;
            b_flags_reg <= in_flags;
        end
    end

    // The read of column x+1 becomes the center for the next request.
    always_ff @(posedge clk)
    begin
        if (b_fire)
        begin
            win_left_reg   <= win_center_reg;
            win_center_reg <= rd_newer;
            win_up_reg     <= rd_older;
        end
    end

    // Laplacian: up + down + left + right - 4 * center.
    always_comb
    begin
        sum4 = SUM_W'(win_up_reg) + SUM_W'(b_value_reg)
             + SUM_W'(win_left_reg) + SUM_W'(rd_newer);
        four_c = {win_center_reg, 2'b00};
        lap_next = $signed({1'b0, sum4}) - $signed({1'b0, four_c});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_lap_reg    <= lap_next;
            c_center_reg <= win_center_reg;
            c_value_reg  <= b_value_reg;
            c_flags_reg  <= b_flags_reg;
        end
    end

    // Row shift write-back: the old newer row becomes the older row.
    assign wr_en    = b_fire;
    assign wr_addr  = b_addr_reg;
    assign wr_older = win_center_reg;
    assign wr_newer = b_value_reg;

    assign c_valid  = c_valid_reg;
    assign c_lap    = c_lap_reg;
    assign c_center = c_center_reg;
    assign c_value  = c_value_reg;
    assign c_flags  = c_flags_reg;

endmodule

// File: hdl/fpsc_update.sv
// ----------------------------------------------------------------------------
// fpsc_update
// Multiplies the Laplacian by the gain, then floors, adds the center and
// saturates to the legal cell range.
// ----------------------------------------------------------------------------
module fpsc_update #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic [fpsc_pkg::GAIN_W-1:0]   gain,
    input  logic                          c_valid,
    input  logic signed [fpsc_pkg::INT_BITS+FRAC_BITS+2:0] c_lap,
    input  logic [fpsc_pkg::INT_BITS+FRAC_BITS-1:0] c_center,
    input  logic [fpsc_pkg::INT_BITS+FRAC_BITS-1:0] c_value,
    input  fpsc_pkg::fpsc_flags_t         c_flags,
    output logic                          d_valid,
    output logic [fpsc_pkg::INT_BITS+FRAC_BITS-1:0] d_first,
    output logic [fpsc_pkg::INT_BITS+FRAC_BITS-1:0] d_second,
    output fpsc_pkg::fpsc_flags_t         d_flags
);
    import fpsc_pkg::*;

    localparam int DATA_W = INT_BITS + FRAC_BITS;
    localparam int LAP_W  = DATA_W + 3;
    localparam int PROD_W = LAP_W + GAIN_W + 1;
    localparam int STEP_W = PROD_W - GAIN_W;
    localparam int RES_W  = STEP_W + 1;
    localparam logic [DATA_W-1:0] VALUE_MAX = {INT_BITS'(VALUE_INT_MAX), {FRAC_BITS{1'b0}}};

    logic                     d_valid_reg;
    logic signed [PROD_W-1:0] d_prod_reg;
    logic [DATA_W-1:0]        d_center_reg;
    logic [DATA_W-1:0]        d_value_reg;
    fpsc_flags_t              d_flags_reg;

    logic signed [STEP_W-1:0] step;
    logic signed [RES_W-1:0]  res;
    logic [DATA_W-1:0]        clamped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_valid_reg <= c_valid;
        end
    end

    // Product stage.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_prod_reg   <= c_lap * $signed({1'b0, gain});
            d_center_reg <= c_center;
            d_value_reg  <= c_value;
            d_flags_reg  <= c_flags;
        end
    end

    // Floor by the arithmetic shift, add the center, saturate.
    always_comb
    begin
        step = $signed(d_prod_reg[PROD_W-1:GAIN_W]);
        res  = RES_W'($signed({1'b0, d_center_reg})) + RES_W'(step);
        if (res[RES_W-1])
        begin
            clamped = '0;
        end
        else if ($unsigned(res) > RES_W'(VALUE_MAX))
        begin
            clamped = VALUE_MAX;
        end
        else
        begin
            clamped = res[DATA_W-1:0];
        end
    end

    // Border cells keep their value unclamped.
    assign d_first  = d_flags_reg.interior ? clamped : d_center_reg;
    assign d_second = d_value_reg;
    assign d_valid  = d_valid_reg;
    assign d_flags  = d_flags_reg;

endmodule

// File: hdl/fpsc_out_buf.sv
// ----------------------------------------------------------------------------
// fpsc_out_buf
// Output register with one extra slot, so an input that causes two results
// hands both over at once and they leave on consecutive handshakes.
// ----------------------------------------------------------------------------
module fpsc_out_buf #(
    parameter int DATA_W  = 23,
    parameter int TDATA_W = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic [DATA_W-1:0]     first,
    input  logic [DATA_W-1:0]     second,
    input  fpsc_pkg::fpsc_flags_t flags,
    output logic                  can_load,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser
);
    import fpsc_pkg::*;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_last_reg;
    logic              out_eof_reg;
    logic              sec_valid_reg;
    logic [DATA_W-1:0] sec_value_reg;
    logic              sec_eof_reg;
    logic              take;
    logic              fill;

    assign take     = out_valid_reg && m_tready;
    assign can_load = !out_valid_reg || (m_tready && !sec_valid_reg);
    assign fill     = load && flags.has_first;

    // Slot control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sec_valid_reg <= 1'b0;
        end
        else if (fill)
        begin
            out_valid_reg <= 1'b1;
            sec_valid_reg <= flags.has_second;
        end
        else if (take)
        begin
            out_valid_reg <= sec_valid_reg;
            sec_valid_reg <= 1'b0;
        end
    end

    // Slot payload.
    always_ff @(posedge clk)
    begin
        if (fill)
        begin
            out_value_reg <= first;
            out_last_reg  <= !flags.has_second;
            out_eof_reg   <= 1'b0;
            sec_value_reg <= second;
            sec_eof_reg   <= flags.eof;
        end
        else if (take && sec_valid_reg)
        begin
            out_value_reg <= sec_value_reg;
            out_last_reg  <= 1'b1;
            out_eof_reg   <= sec_eof_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_value_reg);
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_eof_reg;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the five-point stencil clamp unit.
// ----------------------------------------------------------------------------
// Cells are streamed in raster order with random gaps on the input side and
// random stalls on the result side. A shadow of the two line stores and the
// row and column counters predicts every result, which is compared field by
// field with the oldest pending one. The run opens at the reset settings with
// a little more than one row of a 1024-wide grid, walks a short table of
// border and clamp cases, and then sweeps many grid sizes and gains with
// random cell values.
// ----------------------------------------------------------------------------
module tb_top;
    import fpsc_pkg::*;

    localparam int DATA_W       = INT_BITS + FRAC_BITS_DEF;
    localparam int TDATA_W      = ((DATA_W + 7) / 8) * 8;
    localparam int MAX_SIDE     = MAX_GRID_DEF;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 450;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int MAX_REPORTS  = 30;

    localparam logic [DATA_W-1:0] CELL_ZERO     = '0;
    localparam logic [DATA_W-1:0] CELL_ALL_ONES = '1;
    localparam logic [DATA_W-1:0] CELL_CEIL     = DATA_W'(VALUE_INT_MAX << FRAC_BITS_DEF);
    localparam logic [GAIN_W-1:0] GAIN_FULL     = '1;

    // Register indexes that the block must ignore.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last_in_run;
        logic              end_of_frame;
    } cell_result_t;

    typedef enum logic {
        ROW_CELL,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] index;
        logic [DATA_W-1:0]    value;
        bit                   typed;
        logic [DATA_W-1:0]    want;
    } plan_row_t;

    // Clock and block ports.
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Typed expectation riding along with the cell on the bus.
    bit                   cell_typed = 1'b0;
    logic [DATA_W-1:0]    cell_want  = '0;

    // Shadow state of the stencil.
    logic [GRID_W-1:0]    grid_reg = GRID_W'(GRID_RESET);
    logic [GAIN_W-1:0]    gain_reg = GAIN_W'(GAIN_RESET);
    int                   col_pos  = 0;
    int                   row_pos  = 0;
    logic [DATA_W-1:0]    older_row [MAX_SIDE];
    logic [DATA_W-1:0]    newer_row [MAX_SIDE];
    cell_result_t         pending [$];

    // Stimulus shaping and run statistics.
    bit                   quiet_phase    = 1'b0;
    int                   level          = 0;
    int                   hold_left      = 0;
    int                   errors         = 0;
    int                   cells_accepted = 0;
    int                   results_seen   = 0;
    int                   interior_count = 0;
    int                   frames_closed  = 0;
    int                   cfg_writes     = 0;
    int                   cycle_count    = 0;

    always #5 clk = ~clk;

    five_point_stencil_clamp_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Side length in use: the register saturated to 3 .. MAX_SIDE.
    function automatic int active_side();
        if (grid_reg < SIDE_MIN)
            return SIDE_MIN;
        if (grid_reg > MAX_SIDE)
            return MAX_SIDE;
        return int'(grid_reg);
    endfunction

    // New interior value: c plus gain times the Laplacian, floored, then clamped.
    function automatic logic [DATA_W-1:0] stencil(input logic [DATA_W-1:0] c,
                                                  input logic [DATA_W-1:0] up,
                                                  input logic [DATA_W-1:0] down,
                                                  input logic [DATA_W-1:0] west,
                                                  input logic [DATA_W-1:0] east);
        longint lap;
        longint sum;
        lap = longint'(up) + longint'(down) + longint'(west) + longint'(east)
            - 4 * longint'(c);
        sum = longint'(c) + ((lap * longint'(gain_reg)) >>> 16);
        if (sum > longint'(CELL_CEIL))
            sum = longint'(CELL_CEIL);
        if (sum < 0)
            sum = 0;
        return DATA_W'(sum);
    endfunction

    // Gap length in cycles: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (quiet_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Cell value: extremes, full-range noise, or values near the phase level so
    // that interior results land between the clamps.
    function automatic logic [DATA_W-1:0] next_cell();
        int r;
        int v;
        r = $urandom_range(0, 9);
        case (r)
            0:       return CELL_ZERO;
            1:       return CELL_CEIL;
            2:       return CELL_ALL_ONES;
            3, 4:    return DATA_W'($urandom);
            8, 9:    return DATA_W'($urandom_range(0, int'(CELL_CEIL)));
            default:
            begin
                v = level + int'($urandom_range(0, 1 << 18)) - (1 << 17);
                if (v < 0)
                    v = 0;
                if (v > int'(CELL_ALL_ONES))
                    v = int'(CELL_ALL_ONES);
                return DATA_W'(v);
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    // Register write as seen by the shadow state.
    task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        case (idx)
            REG_GRID_SIZE:
            begin
                grid_reg = val[GRID_W-1:0];
                col_pos  = 0;
                row_pos  = 0;
            end
            REG_GAIN:
                gain_reg = val[GAIN_W-1:0];
            default:
                ;
        endcase
        cfg_writes++;
    endtask

    // One accepted cell: emit the result for the row above, then the cell's own
    // border result when it sits in the last row.
    task automatic predict_cell(input logic [DATA_W-1:0] v, input bit typed,
                                input logic [DATA_W-1:0] want);
        int           n;
        int           x;
        int           r;
        bit           use_want;
        cell_result_t res;
        n        = active_side();
        x        = (col_pos >= n) ? 0 : col_pos;
        r        = (row_pos >= n) ? 0 : row_pos;
        use_want = typed;
        if (r >= 1)
        begin
            res.value = newer_row[x];
            if (r > 1 && x > 0 && x < n - 1)
            begin
                res.value = stencil(newer_row[x], older_row[x], v,
                                    older_row[x - 1], newer_row[x + 1]);
                interior_count++;
            end
            if (use_want)
            begin
                res.value = want;
                use_want  = 1'b0;
            end
            res.last_in_run  = (r != n - 1);
            res.end_of_frame = 1'b0;
            pending.push_back(res);
        end
        older_row[x] = newer_row[x];
        newer_row[x] = v;
        if (r == n - 1)
        begin
            res.value        = use_want ? want : v;
            res.last_in_run  = 1'b1;
            res.end_of_frame = (x == n - 1);
            pending.push_back(res);
        end
        x++;
        if (x >= n)
        begin
            x = 0;
            r++;
            if (r >= n)
                r = 0;
        end
        col_pos = x;
        row_pos = r;
        cells_accepted++;
    endtask

    task automatic check_result();
        cell_result_t want;
        if (pending.size() == 0)
        begin
            report_mismatch("result with none pending", 0, m_tdata);
        end
        else
        begin
            want = pending.pop_front();
            if (m_tdata[DATA_W-1:0] !== want.value)
                report_mismatch("out_value", want.value, m_tdata[DATA_W-1:0]);
            if (m_tlast !== want.last_in_run)
                report_mismatch("last_in_run", want.last_in_run, m_tlast);
            if (m_tuser !== want.end_of_frame)
                report_mismatch("end_of_frame", want.end_of_frame, m_tuser);
            if (want.end_of_frame)
                frames_closed++;
        end
        results_seen++;
    endtask

    // Sample every handshake at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                apply_cfg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                predict_cell(s_tdata[DATA_W-1:0], cell_typed, cell_want);
            if (m_tvalid && m_tready)
                check_result();
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("run stopped at the cycle limit of %0d", CYCLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // Result side: ready with random stalls.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                hold_left <= pick_gap();
        end
    end

    // Offer one cell and wait for its request to be taken. Starts and ends on
    // a falling edge.
    task automatic send_cell(input logic [DATA_W-1:0] v, input bit typed,
                             input logic [DATA_W-1:0] want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= TDATA_W'(v);
        cell_typed <= typed;
        cell_want  <= want;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop sending, then wait for every pending result and a spare drain period.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    plan_row_t plan [$];

    task automatic add_row(input row_kind_t kind, input logic [CFG_IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] value, input bit typed,
                           input logic [DATA_W-1:0] want);
        plan_row_t row;
        row.kind  = kind;
        row.index = idx;
        row.value = value;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endtask

    initial
    begin
        int                phases;
        int                random_cells;
        int                count;
        int                n;
        int                guard;
        logic [CFG_W-1:0]  val;
        bit                gain_first;

        phases       = 0;
        random_cells = 0;

        // Grid size with spare upper bits set: acts as the largest grid.
        add_row(ROW_CFG,  REG_GRID_SIZE, 23'hFFFF, 0, CELL_ZERO);
        add_row(ROW_CELL, REG_GRID_SIZE, CELL_ALL_ONES, 0, CELL_ZERO);
        add_row(ROW_CELL, REG_GRID_SIZE, CELL_ZERO, 0, CELL_ZERO);
        // Grid size zero acts as 3; full gain; spare indexes are ignored.
        add_row(ROW_CFG,  REG_GRID_SIZE, CELL_ZERO, 0, CELL_ZERO);
        add_row(ROW_CFG,  REG_GAIN, DATA_W'(GAIN_FULL), 0, CELL_ZERO);
        add_row(ROW_CFG,  REG_SPARE_LO, 23'h0005, 0, CELL_ZERO);
        add_row(ROW_CFG,  REG_SPARE_HI, CELL_ZERO, 0, CELL_ZERO);
        // Frame with a dark center between bright neighbors: clamps high.
        add_row(ROW_CELL, REG_GAIN, CELL_ALL_ONES, 0, CELL_ZERO);
        add_row(ROW_CELL, REG_GAIN, CELL_ALL_ONES, 0, CELL_ZERO);
        add_row(ROW_CELL, REG_GAIN, CELL_ZERO, 0, CELL_ZERO);
        add_row(ROW_CELL, REG_GAIN, CELL_ALL_ONES, 1, CELL_ALL_ONES);
        add_row(ROW_CELL, REG_GAIN, CELL_ZERO, 1, CELL_ALL_ONES);
        add_row(ROW_CELL, REG_GAIN, CELL_ALL_ONES, 1, CELL_ZERO);
        add_row(ROW_CELL, REG_GAIN, 23'h555555, 1, CELL_ALL_ONES);
        add_row(ROW_CELL, REG_GAIN, CELL_ALL_ONES, 1, CELL_CEIL);
        add_row(ROW_CELL, REG_GAIN, 23'h2AAAAA, 1, CELL_ALL_ONES);
        // Frame with a bright center; gain drops to zero in the middle of it,
        // so the center passes through and only the upper clamp applies.
        add_row(ROW_CELL, REG_GAIN, CELL_ZERO, 0, CELL_ZERO);
        add_row(ROW_CELL, REG_GAIN, CELL_ZERO, 0, CELL_ZERO);
        add_row(ROW_CELL, REG_GAIN, CELL_ZERO, 0, CELL_ZERO);
        add_row(ROW_CELL, REG_GAIN, CELL_ZERO, 1, CELL_ZERO);
        add_row(ROW_CELL, REG_GAIN, CELL_ALL_ONES, 1, CELL_ZERO);
        add_row(ROW_CELL, REG_GAIN, CELL_ZERO, 1, CELL_ZERO);
        add_row(ROW_CFG,  REG_GAIN, CELL_ZERO, 0, CELL_ZERO);
        add_row(ROW_CELL, REG_GAIN, CELL_ZERO, 1, CELL_ZERO);
        add_row(ROW_CELL, REG_GAIN, CELL_ZERO, 1, CELL_CEIL);
        add_row(ROW_CELL, REG_GAIN, CELL_ZERO, 1, CELL_ZERO);

        // Reset.
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: a 1024-wide grid, one row and a little of the second.
        level = $urandom_range(0, int'(CELL_CEIL));
        repeat (MAX_SIDE + $urandom_range(16, 64))
            send_cell(next_cell(), 1'b0, CELL_ZERO);
        settle();

        // Directed table.
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(plan[i].index, CFG_W'(plan[i].value));
            end
            else
            begin
                send_cell(plan[i].value, plan[i].typed, plan[i].want);
            end
        end
        settle();

        // Random phases, each with its own settings and idle pattern.
        while (random_cells < RANDOM_ITEMS)
        begin
            phases++;
            quiet_phase = ($urandom_range(0, 4) == 0);
            level       = $urandom_range(0, int'(CELL_CEIL));
            gain_first  = 1'($urandom_range(0, 1));
            if (gain_first && $urandom_range(0, 9) < 7)
                write_reg(REG_GAIN, ($urandom_range(0, 9) == 0) ? GAIN_FULL :
                                    ($urandom_range(0, 8) == 0) ? '0 :
                                    CFG_W'($urandom_range(0, 65535)));
            if ($urandom_range(0, 9) < 8)
            begin
                case ($urandom_range(0, 19))
                    0, 1:       val = CFG_W'($urandom_range(0, 2));
                    2, 3, 4, 5,
                    6, 7, 8:    val = CFG_W'($urandom_range(3, 6));
                    9, 10, 11,
                    12, 13, 14: val = CFG_W'($urandom_range(7, 16));
                    15, 16, 17: val = CFG_W'($urandom_range(17, 40));
                    18:         val = CFG_W'($urandom_range(1023, 1025));
                    default:    val = CFG_W'(2047);
                endcase
                val[CFG_W-1:GRID_W] = (CFG_W-GRID_W)'($urandom);
                write_reg(REG_GRID_SIZE, val);
            end
            if (!gain_first && $urandom_range(0, 9) < 7)
                write_reg(REG_GAIN, ($urandom_range(0, 9) == 0) ? GAIN_FULL :
                                    ($urandom_range(0, 8) == 0) ? '0 :
                                    CFG_W'($urandom_range(0, 65535)));
            if ($urandom_range(0, 9) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_W'($urandom));

            n = active_side();
            if (n <= 8)
                count = n * n * $urandom_range(1, 2) + $urandom_range(0, n * n - 1);
            else if (n <= 40)
                count = n * n + $urandom_range(0, 2 * n);
            else
                count = $urandom_range(n, 2 * n + 40);
            // Keep the total near the planned number of random cells.
            if (count > RANDOM_ITEMS - random_cells)
                count = RANDOM_ITEMS - random_cells;
            repeat (count)
                send_cell(next_cell(), 1'b0, CELL_ZERO);
            random_cells += count;
            settle();
        end

        // Final drain, bounded so that lost results show up as leftovers.
        s_tvalid <= 1'b0;
        guard = 0;
        while (pending.size() != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (2 * DRAIN_CYCLES) @(negedge clk);
        if (pending.size() != 0)
            report_mismatch("results never delivered", pending.size(), 0);

        $display("Streamed %0d cells and checked %0d results, %0d of them interior stencil cells.",
                 cells_accepted, results_seen, interior_count);
        $display("Made %0d register writes over %0d random phases; %0d frames ran to their end.",
                 cfg_writes, phases, frames_closed);
        if (errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("%0d mismatches found", errors);
            $display("status: fail");
        end
        $finish;
    end

endmodule
